// File: hdl/rat_pkg.sv
package rat_pkg;

  localparam int LAYER_W   = 1;
  localparam int CELL_X_W  = 8;
  localparam int CELL_Y_W  = 7;
  localparam int MAP_X_W   = 6;
  localparam int MAP_Y_W   = 5;
  localparam int TIME_W    = 32;
  localparam int AGE_W     = 32;
  localparam int STEP_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // reciprocal multiply for the coarse map coordinates
  localparam int RECIP_SH  = 24;
  localparam int RECIP_W   = RECIP_SH + 1;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_EPOCH = 1'd1;

  localparam logic [AGE_W-1:0] AGE_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic clear;
    logic load;
    logic div;
    logic pix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic report;
  } sts_t;

endpackage

// File: hdl/rat_ram.sv
module rat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rat_ctrl.sv
module rat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rat_pkg::sts_t sts_i,
  output rat_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ARM   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       stall;

  assign stall = sts_i.report && out_valid_q && !out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_ARM;
      end
      S_ARM: begin
        cmd_o.pix = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        if (!stall) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.commit && sts_i.report) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/rat_dpath.sv
module rat_dpath #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 128,
  parameter int RATIO_X     = 4,
  parameter int RATIO_Y     = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rat_pkg::cmd_t                      cmd_i,
  output rat_pkg::sts_t                      sts_o,
  input  logic                               cfg_we_i,
  input  logic [rat_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rat_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [rat_pkg::LAYER_W-1:0]        layer_sel_i,
  input  logic [rat_pkg::CELL_X_W-1:0]       cell_x_i,
  input  logic [rat_pkg::CELL_Y_W-1:0]       cell_y_i,
  input  logic                               visited_i,
  input  logic [rat_pkg::TIME_W-1:0]         current_time_i,
  output logic [rat_pkg::LAYER_W-1:0]        report_layer_o,
  output logic [rat_pkg::MAP_X_W-1:0]        map_x_o,
  output logic [rat_pkg::MAP_Y_W-1:0]        map_y_o,
  output logic [rat_pkg::TIME_W-1:0]         revisit_time_o
);

  localparam int XMAX   = 1 << rat_pkg::CELL_X_W;
  localparam int YMAX   = 1 << rat_pkg::CELL_Y_W;
  localparam int GW_EFF = (GRID_WIDTH > XMAX) ? XMAX : GRID_WIDTH;
  localparam int GH_EFF = (GRID_HEIGHT > YMAX) ? YMAX : GRID_HEIGHT;
  localparam int XW     = $clog2(GW_EFF);
  localparam int YW     = $clog2(GH_EFF);
  localparam int CW     = 1 + XW + YW;
  localparam int MAP_W  = (GW_EFF + RATIO_X - 1) / RATIO_X;
  localparam int MAP_H  = (GH_EFF + RATIO_Y - 1) / RATIO_Y;
  localparam int MXW    = (MAP_W > 1) ? $clog2(MAP_W) : 1;
  localparam int MYW    = (MAP_H > 1) ? $clog2(MAP_H) : 1;
  localparam int AW     = 1 + MXW + MYW;
  localparam int PX_W   = rat_pkg::CELL_X_W + rat_pkg::RECIP_W;
  localparam int PY_W   = rat_pkg::CELL_Y_W + rat_pkg::RECIP_W;
  localparam int QX_W   = rat_pkg::CELL_X_W + 7;
  localparam int QY_W   = rat_pkg::CELL_Y_W + 7;
  localparam logic [rat_pkg::RECIP_W-1:0] RECIP_X =
    rat_pkg::RECIP_W'(((1 << rat_pkg::RECIP_SH) + RATIO_X - 1) / RATIO_X);
  localparam logic [rat_pkg::RECIP_W-1:0] RECIP_Y =
    rat_pkg::RECIP_W'(((1 << rat_pkg::RECIP_SH) + RATIO_Y - 1) / RATIO_Y);

  logic [rat_pkg::STEP_W-1:0]   step_q;
  logic [rat_pkg::TIME_W-1:0]   epoch_q;
  logic [CW-1:0]                clr_q;

  logic                         layer_q;
  logic [rat_pkg::CELL_X_W-1:0] x_q;
  logic [rat_pkg::CELL_Y_W-1:0] y_q;
  logic                         visit_q;
  logic [rat_pkg::TIME_W-1:0]   now_q;
  logic [rat_pkg::CELL_X_W-1:0] mx_q;
  logic [rat_pkg::CELL_Y_W-1:0] my_q;
  logic                         pix_q;

  logic                         out_layer_q;
  logic [rat_pkg::MAP_X_W-1:0]  out_mx_q;
  logic [rat_pkg::MAP_Y_W-1:0]  out_my_q;
  logic [rat_pkg::TIME_W-1:0]   out_rt_q;

  logic [PX_W-1:0]              prod_x;
  logic [PY_W-1:0]              prod_y;
  logic [QX_W-1:0]              back_x;
  logic [QY_W-1:0]              back_y;

  logic [CW-1:0]                cell_addr;
  logic [AW-1:0]                arm_addr;
  logic [rat_pkg::AGE_W-1:0]    age;
  logic                         armed;
  logic                         oob;
  logic                         age_pos;
  logic                         report;
  logic [rat_pkg::AGE_W-1:0]    sum;
  logic [rat_pkg::AGE_W-1:0]    new_age;
  logic [rat_pkg::TIME_W-1:0]   rt;
  logic                         wr_cell;
  logic                         wr_arm;

  logic                         cell_we;
  logic [CW-1:0]                cell_waddr;
  logic [rat_pkg::AGE_W-1:0]    cell_wdata;
  logic                         arm_we;
  logic [AW-1:0]                arm_waddr;
  logic                         arm_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= rat_pkg::STEP_W'(1);
      epoch_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rat_pkg::REG_TIME_STEP:   step_q  <= cfg_wdata_i[rat_pkg::STEP_W-1:0];
          rat_pkg::REG_START_EPOCH: epoch_q <= cfg_wdata_i[rat_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + CW'(1);
      end
    end
  end

  assign prod_x = PX_W'(x_q) * PX_W'(RECIP_X);
  assign prod_y = PY_W'(y_q) * PY_W'(RECIP_Y);
  assign back_x = QX_W'(mx_q) * QX_W'(RATIO_X);
  assign back_y = QY_W'(my_q) * QY_W'(RATIO_Y);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      layer_q <= layer_sel_i;
      x_q     <= cell_x_i;
      y_q     <= cell_y_i;
      visit_q <= visited_i;
      now_q   <= current_time_i;
    end
    if (cmd_i.div) begin
      mx_q <= prod_x[rat_pkg::RECIP_SH +: rat_pkg::CELL_X_W];
      my_q <= prod_y[rat_pkg::RECIP_SH +: rat_pkg::CELL_Y_W];
    end
    if (cmd_i.pix) begin
      pix_q <= (back_x == QX_W'(x_q)) && (back_y == QY_W'(y_q));
    end
    if (cmd_i.commit && report) begin
      out_layer_q <= layer_q;
      out_mx_q    <= mx_q[rat_pkg::MAP_X_W-1:0];
      out_my_q    <= my_q[rat_pkg::MAP_Y_W-1:0];
      out_rt_q    <= rt;
    end
  end

  assign cell_addr = {layer_q, x_q[XW-1:0], y_q[YW-1:0]};
  assign arm_addr  = {layer_q, mx_q[MXW-1:0], my_q[MYW-1:0]};

  assign oob     = (32'(x_q) >= 32'(GRID_WIDTH)) || (32'(y_q) >= 32'(GRID_HEIGHT));
  assign age_pos = !age[rat_pkg::AGE_W-1] && (age != '0);
  assign report  = !oob && visit_q && pix_q && armed &&
                   (layer_q ? age_pos : (age != '0));
  assign rt      = age[rat_pkg::AGE_W-1] ? (now_q - epoch_q) : age;

  // age is non-negative here, so the sum cannot wrap past bit 31
  assign sum     = age + rat_pkg::AGE_W'(step_q);
  assign new_age = visit_q ? '0 :
                   (sum[rat_pkg::AGE_W-1] ? rat_pkg::AGE_MAX : sum);
  assign wr_cell = !oob && (visit_q || !age[rat_pkg::AGE_W-1]);
  assign wr_arm  = !oob && (visit_q ? report : age_pos);

  assign cell_we    = cmd_i.clear || (cmd_i.commit && wr_cell);
  assign cell_waddr = cmd_i.clear ? clr_q : cell_addr;
  assign cell_wdata = cmd_i.clear ? (clr_q[CW-1] ? '0 : '1) : new_age;
  assign arm_we     = cmd_i.clear || (cmd_i.commit && wr_arm);
  assign arm_waddr  = cmd_i.clear ? clr_q[AW-1:0] : arm_addr;
  assign arm_wdata  = cmd_i.clear || !visit_q;

  rat_ram #(
    .WIDTH (rat_pkg::AGE_W),
    .DEPTH (1 << CW)
  ) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_addr),
    .rdata_o (age)
  );

  rat_ram #(
    .WIDTH (1),
    .DEPTH (1 << AW)
  ) u_arm_ram (
    .clk_i   (clk_i),
    .we_i    (arm_we),
    .waddr_i (arm_waddr),
    .wdata_i (arm_wdata),
    .raddr_i (arm_addr),
    .rdata_o (armed)
  );

  assign sts_o.clear_done = (clr_q == '1);
  assign sts_o.report     = report;

  assign report_layer_o = out_layer_q;
  assign map_x_o        = out_mx_q;
  assign map_y_o        = out_my_q;
  assign revisit_time_o = out_rt_q;

endmodule

// File: hdl/revisit_age_table.sv
// Revisit age table: two layers (ideal, actual) of per-cell ages.
// Input channel (in_valid_i/in_ready_o): one cell update per transfer,
// naming the layer, the cell and whether it is visited at current_time_i.
// Output channel (out_valid_o/out_ready_i): at most one revisit report per
// input item, for the coarse map pixel of the visited cell.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 age step, 1 epoch start); write only while idle.
// Each item passes through capture, map coordinate multiply, pixel check
// and age/mark memory read, then read-modify-write of both memories.
// The mark address needs the map coordinates, so multiply, mark read and
// update follow one another.
// A report appears in the output register on the cycle after the last step.
// After reset a clearing pass writes every age entry and report mark, one
// address per cycle; in_ready_o stays low until it ends.
// A stalled report holds in the output register while the next item is
// taken; an item that must report waits in its last step until the
// register is free.
module revisit_age_table #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 128,
  parameter int RATIO_X     = 4,
  parameter int RATIO_Y     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rat_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rat_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rat_pkg::LAYER_W-1:0]    layer_sel_i,
  input  logic [rat_pkg::CELL_X_W-1:0]   cell_x_i,
  input  logic [rat_pkg::CELL_Y_W-1:0]   cell_y_i,
  input  logic                           visited_i,
  input  logic [rat_pkg::TIME_W-1:0]     current_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rat_pkg::LAYER_W-1:0]    report_layer_o,
  output logic [rat_pkg::MAP_X_W-1:0]    map_x_o,
  output logic [rat_pkg::MAP_Y_W-1:0]    map_y_o,
  output logic [rat_pkg::TIME_W-1:0]     revisit_time_o
);

  rat_pkg::cmd_t cmd;
  rat_pkg::sts_t sts;

  rat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rat_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .RATIO_X     (RATIO_X),
    .RATIO_Y     (RATIO_Y)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .layer_sel_i    (layer_sel_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .visited_i      (visited_i),
    .current_time_i (current_time_i),
    .report_layer_o (report_layer_o),
    .map_x_o        (map_x_o),
    .map_y_o        (map_y_o),
    .revisit_time_o (revisit_time_o)
  );

endmodule

// File: hdl/rat_checker.sv
module rat_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rat_pkg::TIME_W-1:0]  revisit_time_o,
  input logic [rat_pkg::MAP_X_W-1:0] map_x_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("report dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(revisit_time_o) && $stable(map_x_o))
    else $error("report changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer while an item is in work");

  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("report raised without an item in work");

endmodule

bind revisit_age_table rat_checker u_rat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .revisit_time_o (revisit_time_o),
  .map_x_o        (map_x_o)
);

// File: sim/tb_revisit_age_table.sv
module tb_revisit_age_table;
  timeunit 1ns;
  timeprecision 1ps;

  import rat_pkg::*;

  localparam int GW = 256;
  localparam int GH = 128;
  localparam int RX = 4;
  localparam int RY = 4;
  localparam int MW = (GW + RX - 1) / RX;
  localparam int MH = (GH + RY - 1) / RY;

  localparam logic [LAYER_W-1:0] LAYER_IDEAL  = 1'b0;
  localparam logic [LAYER_W-1:0] LAYER_ACTUAL = 1'b1;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RUN_LIMIT    = 2_000_000;

  typedef struct packed {
    logic [LAYER_W-1:0]  layer;
    logic [CELL_X_W-1:0] x;
    logic [CELL_Y_W-1:0] y;
    logic                visit;
    logic [TIME_W-1:0]   now;
  } cell_upd_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [MAP_X_W-1:0] mx;
    logic [MAP_Y_W-1:0] my;
    logic [TIME_W-1:0]  rtime;
  } revisit_rpt_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [LAYER_W-1:0]    layer_sel_i    = '0;
  logic [CELL_X_W-1:0]   cell_x_i       = '0;
  logic [CELL_Y_W-1:0]   cell_y_i       = '0;
  logic                  visited_i      = 1'b0;
  logic [TIME_W-1:0]     current_time_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [LAYER_W-1:0]    report_layer_o;
  logic [MAP_X_W-1:0]    map_x_o;
  logic [MAP_Y_W-1:0]    map_y_o;
  logic [TIME_W-1:0]     revisit_time_o;

  revisit_age_table #(
    .GRID_WIDTH  (GW),
    .GRID_HEIGHT (GH),
    .RATIO_X     (RX),
    .RATIO_Y     (RY)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .layer_sel_i    (layer_sel_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .visited_i      (visited_i),
    .current_time_i (current_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_layer_o (report_layer_o),
    .map_x_o        (map_x_o),
    .map_y_o        (map_y_o),
    .revisit_time_o (revisit_time_o)
  );

  // shadow of the block's state and registers
  logic signed [AGE_W-1:0] age_q [2][GW][GH];
  bit                      armed_q [2][MW][MH];
  logic [STEP_W-1:0]       step_cfg  = 16'd1;
  logic [TIME_W-1:0]       epoch_cfg = '0;

  cell_upd_t    upd_queue [$];
  revisit_rpt_t exp_reports [$];
  int unsigned  err_cnt = 0;

  int unsigned in_gap    = 0;
  int unsigned in_quiet  = 0;
  int unsigned out_gap   = 0;
  int unsigned out_quiet = 0;
  cell_upd_t   drv_item;
  cell_upd_t   acc_item;
  revisit_rpt_t acc_rpt;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int l = 0; l < 2; l++) begin
      for (int x = 0; x < GW; x++) begin
        for (int y = 0; y < GH; y++) begin
          age_q[l][x][y] = (l == LAYER_IDEAL) ? -32'sd1 : 32'sd0;
        end
      end
      for (int x = 0; x < MW; x++) begin
        for (int y = 0; y < MH; y++) begin
          armed_q[l][x][y] = 1'b1;
        end
      end
    end
  end

  // Applies one cell update to the shadow tables; returns 1 when it reports.
  function automatic bit age_cell_update(input cell_upd_t u, output revisit_rpt_t r);
    logic signed [AGE_W-1:0] a;
    int unsigned mx;
    int unsigned my;
    bit pix;
    longint sum;
    r = '0;
    if (u.x >= GW || u.y >= GH) return 1'b0;
    mx  = u.x / RX;
    my  = u.y / RY;
    pix = (u.x % RX == 0) && (u.y % RY == 0);
    a   = age_q[u.layer][u.x][u.y];
    if (!u.visit) begin
      if (a >= 0) begin
        if (a > 0) armed_q[u.layer][mx][my] = 1'b1;
        sum = longint'(a) + longint'(step_cfg);
        if (sum > longint'(AGE_MAX)) sum = longint'(AGE_MAX);
        age_q[u.layer][u.x][u.y] = sum[AGE_W-1:0];
      end
      return 1'b0;
    end
    age_q[u.layer][u.x][u.y] = '0;
    if (pix && armed_q[u.layer][mx][my] &&
        ((u.layer == LAYER_IDEAL && a != 0) || (u.layer == LAYER_ACTUAL && a > 0))) begin
      armed_q[u.layer][mx][my] = 1'b0;
      r.layer = u.layer;
      r.mx    = mx[MAP_X_W-1:0];
      r.my    = my[MAP_Y_W-1:0];
      r.rtime = (a < 0) ? u.now - epoch_cfg : a;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned p;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    p = $urandom_range(99);
    if (p < 3) begin
      quiet = $urandom_range(50, 20);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void push_upd(input logic [LAYER_W-1:0] layer, input int unsigned x,
                                   input int unsigned y, input bit visit,
                                   input logic [TIME_W-1:0] now);
    cell_upd_t u;
    u.layer = layer;
    u.x     = x[CELL_X_W-1:0];
    u.y     = y[CELL_Y_W-1:0];
    u.visit = visit;
    u.now   = now;
    upd_queue = {upd_queue, u};
  endfunction

  // cell inside a coarse pixel: mostly the pixel cell itself, else a neighbor
  function automatic void push_near(input logic [LAYER_W-1:0] layer, input int unsigned mx,
                                    input int unsigned my, input bit visit);
    int unsigned dx;
    int unsigned dy;
    dx = 0;
    dy = 0;
    if ($urandom_range(99) >= 70) begin
      dx = $urandom_range(RX - 1);
      dy = $urandom_range(RY - 1);
    end
    push_upd(layer, mx * RX + dx, my * RY + dy, visit, $urandom());
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TIME_STEP) step_cfg = val[STEP_W-1:0];
    else epoch_cfg = val;
  endtask

  task automatic drain();
    while (upd_queue.size() != 0 || in_valid_i || exp_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Age-then-visit sequences on a few hot coarse pixels, mixed with random updates.
  task automatic random_phase(input int unsigned n);
    logic [LAYER_W-1:0] hl [8];
    int unsigned hx [8];
    int unsigned hy [8];
    int unsigned cnt;
    int unsigned h;
    int unsigned k;
    for (int i = 0; i < 8; i++) begin
      hl[i] = LAYER_W'($urandom_range(1, 0));
      hx[i] = $urandom_range(MW - 1);
      hy[i] = $urandom_range(MH - 1);
    end
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 20) begin
        push_upd(LAYER_W'($urandom_range(1, 0)), $urandom_range(GW - 1),
                 $urandom_range(GH - 1), 1'($urandom_range(1, 0)), $urandom());
        cnt++;
      end else begin
        h = $urandom_range(7);
        k = $urandom_range(4);
        repeat (k) push_near(hl[h], hx[h], hy[h], 1'b0);
        push_near(hl[h], hx[h], hy[h], 1'b1);
        cnt += k + 1;
      end
    end
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (upd_queue.size() != 0) begin
        drv_item = upd_queue.pop_front();
        layer_sel_i    <= drv_item.layer;
        cell_x_i       <= drv_item.x;
        cell_y_i       <= drv_item.y;
        visited_i      <= drv_item.visit;
        current_time_i <= drv_item.now;
        in_valid_i     <= 1'b1;
        in_gap         <= pick_gap(in_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else if (out_gap != 0) begin
      out_gap     <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_gap     <= pick_gap(out_quiet);
    end
  end

  // input transfer: predict
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      acc_item.layer = layer_sel_i;
      acc_item.x     = cell_x_i;
      acc_item.y     = cell_y_i;
      acc_item.visit = visited_i;
      acc_item.now   = current_time_i;
      if (age_cell_update(acc_item, acc_rpt)) exp_reports = {exp_reports, acc_rpt};
    end
  end

  // output transfer: check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_reports.size() == 0) begin
        err_cnt++;
        $display("%0t: expected no report, got layer %0d map %0d,%0d time %0h", $time,
                 report_layer_o, map_x_o, map_y_o, revisit_time_o);
      end else begin
        acc_rpt = exp_reports.pop_front();
        if (acc_rpt.layer !== report_layer_o || acc_rpt.mx !== map_x_o ||
            acc_rpt.my !== map_y_o || acc_rpt.rtime !== revisit_time_o) begin
          err_cnt++;
          $display("%0t: report mismatch, expected layer %0d map %0d,%0d time %0h,",
                   $time, acc_rpt.layer, acc_rpt.mx, acc_rpt.my, acc_rpt.rtime);
          $display("  got layer %0d map %0d,%0d time %0h", report_layer_o, map_x_o,
                   map_y_o, revisit_time_o);
        end
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    write_reg(REG_TIME_STEP, 32'd3);
    write_reg(REG_START_EPOCH, 32'h8000_0000);

    // never-visited ideal pixel, wrap of now - epoch; then zero age
    push_upd(LAYER_IDEAL, 0, 0, 1'b1, 32'h0000_0010);
    push_upd(LAYER_IDEAL, 0, 0, 1'b1, $urandom());
    // ageing from zero does not re-arm, the second ageing does
    push_upd(LAYER_IDEAL, 0, 0, 1'b0, $urandom());
    push_upd(LAYER_IDEAL, 0, 0, 1'b0, $urandom());
    push_upd(LAYER_IDEAL, 0, 0, 1'b1, $urandom());
    // actual layer at zero age reports nothing
    push_upd(LAYER_ACTUAL, GW - RX, GH - RY, 1'b1, $urandom());
    // neighbor re-arms the last coarse pixel
    push_upd(LAYER_ACTUAL, GW - 1, GH - 1, 1'b0, $urandom());
    push_upd(LAYER_ACTUAL, GW - 1, GH - 1, 1'b0, $urandom());
    push_upd(LAYER_ACTUAL, GW - RX, GH - RY, 1'b0, $urandom());
    push_upd(LAYER_ACTUAL, GW - RX, GH - RY, 1'b1, $urandom());
    push_upd(LAYER_ACTUAL, GW - RX, GH - RY, 1'b1, $urandom());
    // negative age stays when aged; non-pixel visit is silent
    push_upd(LAYER_IDEAL, GW - 1, GH - 1, 1'b0, 32'hFFFF_FFFF);
    push_upd(LAYER_IDEAL, GW - 1, GH - 1, 1'b1, 32'hFFFF_FFFF);
    push_upd(LAYER_IDEAL, GW - 1, GH - 1, 1'b0, 32'h0);
    push_upd(LAYER_IDEAL, GW - RX, 0, 1'b1, 32'hFFFF_FFFF);
    push_upd(LAYER_IDEAL, 0, GH - RY, 1'b1, 32'h0);
    push_upd(LAYER_ACTUAL, 0, 0, 1'b0, 32'h5555_5555);
    push_upd(LAYER_ACTUAL, 0, 0, 1'b0, 32'hAAAA_AAAA);
    push_upd(LAYER_ACTUAL, 0, 0, 1'b1, 32'h0);
    drain();

    write_reg(REG_TIME_STEP, 32'd65535);
    write_reg(REG_START_EPOCH, 32'hFFFF_FFFF);
    random_phase(100);

    // zero step: ages hold, re-arming still happens
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_START_EPOCH, 32'd0);
    random_phase(100);

    write_reg(REG_TIME_STEP, 32'd1);
    write_reg(REG_START_EPOCH, $urandom());
    random_phase(100);

    write_reg(REG_TIME_STEP, $urandom_range(65535, 1));
    write_reg(REG_START_EPOCH, $urandom());
    random_phase(100);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
